[design/bps_pkg.sv]
// ============================================================================
// bps_pkg
// Shared types and constants of the backoff poll scheduler.
// ============================================================================
package bps_pkg;

   localparam int unsigned NowW       = 32;
   localparam int unsigned RunW       = 31;
   localparam int unsigned CodeW      = 4;
   localparam int unsigned FailW      = 8;
   localparam int unsigned IntervalW  = 12;
   localparam int unsigned IntervalMsW = 22;
   localparam int unsigned GrownW     = 27;
   localparam int unsigned CsrIndexW  = 2;
   localparam int unsigned ReqDataW   = 80;
   localparam int unsigned RspDataW   = 16;

   localparam logic [IntervalW-1:0]   IntervalMinS   = 12'd15;
   localparam logic [IntervalW-1:0]   IntervalMaxS   = 12'd3600;
   localparam logic [IntervalW-1:0]   IntervalResetS = 12'd60;
   localparam logic [IntervalMsW-1:0] MsPerS         = 22'd1000;
   localparam logic [IntervalMsW-1:0] IntervalResetMs = 22'd60000;
   localparam logic [FailW-1:0]       BackoffShiftMax = 8'd5;
   localparam logic [GrownW-1:0]      BackoffCapMs   = 27'(15 * 60 * 1000);
   localparam logic [FailW-1:0]       FailMax        = 8'd255;

   localparam logic [CsrIndexW-1:0] CSR_POLL_ENABLED   = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_INTERVAL       = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_TARGET_PRESENT = 2'd2;

   localparam logic [CodeW-1:0] CODE_NONE            = 4'd0;
   localparam logic [CodeW-1:0] CODE_SUCCESS         = 4'd1;
   localparam logic [CodeW-1:0] CODE_FAILURE         = 4'd2;
   localparam logic [CodeW-1:0] CODE_TIMED_OUT       = 4'd3;
   localparam logic [CodeW-1:0] CODE_STARTUP_FAILURE = 4'd4;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_POLLING = 2'd1;
   localparam logic [1:0] ST_OK      = 2'd2;
   localparam logic [1:0] ST_ERROR   = 2'd3;

   localparam logic [1:0] CHIME_NONE = 2'd0;
   localparam logic [1:0] CHIME_PASS = 2'd1;
   localparam logic [1:0] CHIME_FAIL = 2'd2;

   typedef struct packed {
      logic [CodeW-1:0] conclusion_code;
      logic [RunW-1:0]  run_id;
      logic             result_ok;
      logic             result_ready;
      logic             target_changed;
      logic             request_now;
      logic             host_active;
      logic             link_up;
      logic [NowW-1:0]  now_ms;
   } item_type;

   typedef struct packed {
      logic [FailW-1:0] failure_count;
      logic [1:0]       chime;
      logic             updated;
      logic             driving;
      logic [1:0]       status;
      logic             start_poll;
   } result_type;

   typedef struct packed {
      logic                   poll_enabled;
      logic                   target_present;
      logic [IntervalMsW-1:0] period_ms;
   } cfg_type;

endpackage

[design/backoff_poll_scheduler.sv]
// ============================================================================
// backoff_poll_scheduler
// Capped exponential backoff poll timer, one scheduler step per transfer.
// ============================================================================
// Each req_ transfer carries one scheduler step (time stamp, link and host
// state, poll request, target change, finished poll result). Each step
// yields exactly one rsp_ transfer with the start pulse, status, display
// ownership, update flag, chime and failure count after the step.
// The csr_ port writes poll_enabled (0), interval_seconds (1, saturated to
// 15..3600) and target_present (2); write it only while no step is in flight.
// A step passes through the input register, then through the step logic
// against the scheduler state into the result register that drives
// rsp_tvalid. Throughput is one step per cycle while rsp_tready is high.
// Reset (synchronous) clears the state, empties both registers and loads
// the register defaults (enabled, 60 s, target present).
// When rsp_tready is low the result holds and one more step waits in the
// input register; req_tready drops only when both are full.
// ============================================================================
module backoff_poll_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // now_ms[31:0], link_up[32], host_active[33], request_now[34],
   // target_changed[35], result_ready[36], result_ok[37], run_id[68:38],
   // conclusion_code[72:69], zero fill [79:73]
   input  logic [bps_pkg::ReqDataW-1:0]   req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // start_poll[0], status[2:1], driving[3], updated[4], chime[6:5],
   // failure_count[14:7], zero fill [15]
   output logic [bps_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                           csr_we,
   input  logic [bps_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [bps_pkg::IntervalW-1:0]  csr_wdata
);

   localparam int unsigned ItemW   = $bits(bps_pkg::item_type);
   localparam int unsigned ResultW = $bits(bps_pkg::result_type);

   logic                  in_valid_ff, in_valid_in;
   bps_pkg::item_type     in_item_ff;
   logic                  out_valid_ff, out_valid_in;
   bps_pkg::result_type   out_ff;
   bps_pkg::result_type   result;
   bps_pkg::cfg_type      cfg;
   logic                  advance;

   assign advance      = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready   = ~in_valid_ff | advance;
   assign in_valid_in  = (req_tvalid & req_tready) | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= bps_pkg::item_type'(req_tdata[ItemW-1:0]);
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   bps_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bps_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(bps_pkg::RspDataW - ResultW){1'b0}}, out_ff};

endmodule

[design/bps_cfg.sv]
// ============================================================================
// bps_cfg
// Configuration registers; the interval is saturated and kept in ms.
// ============================================================================
module bps_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bps_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [bps_pkg::IntervalW-1:0]    csr_wdata,
   output bps_pkg::cfg_type                 cfg
);

   logic                               poll_enabled_ff, poll_enabled_in;
   logic                               target_present_ff, target_present_in;
   logic [bps_pkg::IntervalMsW-1:0]    period_ms_ff, period_ms_in;
   logic [bps_pkg::IntervalW-1:0]      sat_s;

   always_comb begin
      sat_s = csr_wdata;
      if (csr_wdata < bps_pkg::IntervalMinS) begin
         sat_s = bps_pkg::IntervalMinS;
      end else if (csr_wdata > bps_pkg::IntervalMaxS) begin
         sat_s = bps_pkg::IntervalMaxS;
      end
      poll_enabled_in   = poll_enabled_ff;
      target_present_in = target_present_ff;
      period_ms_in      = period_ms_ff;
      if (csr_we) begin
         case (csr_index)
            bps_pkg::CSR_POLL_ENABLED:   poll_enabled_in = csr_wdata[0];
            bps_pkg::CSR_INTERVAL:
               period_ms_in = bps_pkg::IntervalMsW'(
                  bps_pkg::IntervalMsW'(sat_s) * bps_pkg::MsPerS);
            bps_pkg::CSR_TARGET_PRESENT: target_present_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_enabled_ff   <= 1'b1;
         target_present_ff <= 1'b1;
         period_ms_ff      <= bps_pkg::IntervalResetMs;
      end else begin
         poll_enabled_ff   <= poll_enabled_in;
         target_present_ff <= target_present_in;
         period_ms_ff      <= period_ms_in;
      end
   end

   assign cfg.poll_enabled   = poll_enabled_ff;
   assign cfg.target_present = target_present_ff;
   assign cfg.period_ms      = period_ms_ff;

endmodule

[design/bps_core.sv]
// ============================================================================
// bps_core
// Scheduler state and the single-pass step logic for one item.
// ============================================================================
module bps_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  bps_pkg::item_type     item,
   input  bps_pkg::cfg_type      cfg,
   output bps_pkg::result_type   result
);

   logic                           in_flight_ff, in_flight_in;
   logic                           owns_ff, owns_in;
   logic                           pending_ff, pending_in;
   logic                           primed_ff, primed_in;
   logic [bps_pkg::FailW-1:0]      fail_ff, fail_in;
   logic [bps_pkg::NowW-1:0]       next_due_ff, next_due_in;
   logic [bps_pkg::CodeW-1:0]      last_outcome_ff, last_outcome_in;
   logic [bps_pkg::RunW-1:0]       last_run_ff, last_run_in;
   logic [1:0]                     status_ff, status_in;

   logic [bps_pkg::GrownW-1:0]     base, grown, delay;
   logic [2:0]                     shift;
   logic [bps_pkg::NowW-1:0]       since_due;
   logic                           enable, due, same;
   logic [1:0]                     chime;

   always_comb begin
      in_flight_in    = in_flight_ff;
      owns_in         = owns_ff;
      pending_in      = pending_ff | item.target_changed | item.request_now;
      primed_in       = primed_ff & ~item.target_changed;
      fail_in         = fail_ff;
      next_due_in     = next_due_ff;
      last_outcome_in = last_outcome_ff;
      last_run_in     = last_run_ff;
      status_in       = status_ff;
      chime           = bps_pkg::CHIME_NONE;
      same = (item.run_id == last_run_ff) && (item.conclusion_code == last_outcome_ff);

      if (item.result_ready) begin
         in_flight_in = 1'b0;
         if (item.result_ok) begin
            fail_in   = '0;
            status_in = bps_pkg::ST_OK;
            if (primed_in && item.conclusion_code != bps_pkg::CODE_NONE && !same) begin
               if (item.conclusion_code == bps_pkg::CODE_SUCCESS) begin
                  chime = bps_pkg::CHIME_PASS;
               end else if (item.conclusion_code == bps_pkg::CODE_FAILURE ||
                            item.conclusion_code == bps_pkg::CODE_TIMED_OUT ||
                            item.conclusion_code == bps_pkg::CODE_STARTUP_FAILURE) begin
                  chime = bps_pkg::CHIME_FAIL;
               end
            end
            last_outcome_in = item.conclusion_code;
            last_run_in     = item.run_id;
            primed_in       = 1'b1;
         end else begin
            if (fail_ff != bps_pkg::FailMax) begin
               fail_in = fail_ff + 8'd1;
            end
            status_in = bps_pkg::ST_ERROR;
         end
      end

      base  = bps_pkg::GrownW'(cfg.period_ms);
      shift = (fail_in > bps_pkg::BackoffShiftMax) ? 3'(bps_pkg::BackoffShiftMax)
                                                   : fail_in[2:0];
      grown = base << shift;
      if (grown > bps_pkg::BackoffCapMs) begin
         grown = bps_pkg::BackoffCapMs;
      end
      delay = (fail_in == '0 || grown < base) ? base : grown;
      if (item.result_ready) begin
         next_due_in = item.now_ms + bps_pkg::NowW'(delay);
      end

      // a fresh result pushes the due time ahead, so the time check does not make it due then
      since_due = item.now_ms - next_due_ff;
      enable = cfg.poll_enabled & item.link_up & ~item.host_active & cfg.target_present;
      due    = ~owns_ff | (~item.result_ready & ~since_due[bps_pkg::NowW-1]);

      if (!enable) begin
         if (owns_ff) begin
            owns_in = 1'b0;
            if (!in_flight_in) begin
               status_in = bps_pkg::ST_IDLE;
            end
         end
      end else begin
         owns_in = 1'b1;
         if (!owns_ff) begin
            next_due_in = item.now_ms;
         end
         if (in_flight_in) begin
            status_in = bps_pkg::ST_POLLING;
         end else if (pending_in || due) begin
            pending_in   = 1'b0;
            in_flight_in = 1'b1;
            status_in    = bps_pkg::ST_POLLING;
            next_due_in  = item.now_ms + bps_pkg::NowW'(cfg.period_ms);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= 1'b0;
         owns_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         primed_ff    <= 1'b0;
         fail_ff      <= '0;
         next_due_ff  <= '0;
         status_ff    <= bps_pkg::ST_IDLE;
      end else if (step) begin
         in_flight_ff <= in_flight_in;
         owns_ff      <= owns_in;
         pending_ff   <= pending_in;
         primed_ff    <= primed_in;
         fail_ff      <= fail_in;
         next_due_ff  <= next_due_in;
         status_ff    <= status_in;
      end
   end

   // only compared while primed_ff is set, so no reset needed
   always_ff @(posedge clock) begin
      if (step) begin
         last_outcome_ff <= last_outcome_in;
         last_run_ff     <= last_run_in;
      end
   end

   assign result.start_poll    = in_flight_in & ~in_flight_ff | (in_flight_in & item.result_ready);
   assign result.status        = status_in;
   assign result.driving       = owns_in;
   assign result.updated       = item.result_ready;
   assign result.chime         = chime;
   assign result.failure_count = fail_in;

endmodule

[bench/backoff_poll_scheduler_check.sv]
`timescale 1ns / 100ps
// ============================================================================
// backoff_poll_scheduler_check
// Watches the step and status channels and scores every status transfer.
// ============================================================================
// Keeps its own copy of the scheduler state and registers. Each accepted
// step is run through that copy and the outputs it yields are queued; each
// accepted status transfer is compared field by field against the oldest
// queued entry. Register writes are mirrored as they happen.
// ============================================================================
module backoff_poll_scheduler_check
   import bps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [ReqDataW-1:0]   req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RspDataW-1:0]   rsp_tdata,
   input  logic                  csr_we,
   input  logic [CsrIndexW-1:0]  csr_index,
   input  logic [IntervalW-1:0]  csr_wdata,
   output int                    bad_outputs,
   output int                    outputs_owed
);

   logic                 enabled_q;
   logic [IntervalW-1:0] interval_s;
   logic                 target_q;

   logic                 in_flight;
   logic                 owns_display;
   logic                 pending_poll;
   logic                 primed;
   logic [FailW-1:0]     streak;
   logic [31:0]          next_due;
   logic [CodeW-1:0]     last_code;
   logic [31:0]          last_run;
   logic [1:0]           status_q;

   result_type           step_outputs_q[$];
   result_type           want;
   result_type           got;
   item_type             step_in;

   function automatic logic [31:0] backoff_ms();
      logic [31:0] base;
      logic [31:0] grown;
      base = interval_s * 32'd1000;
      if (streak == '0) begin
         return base;
      end
      grown = base << ((streak > BackoffShiftMax) ? BackoffShiftMax : streak);
      if (grown > BackoffCapMs) begin
         grown = BackoffCapMs;
      end
      return (grown > base) ? grown : base;
   endfunction

   function automatic logic [1:0] judge_chime(input logic [RunW-1:0] run,
                                              input logic [CodeW-1:0] code);
      logic [1:0] sound;
      logic       unchanged;
      unchanged = ({1'b0, run} == last_run) && (code == last_code);
      sound = CHIME_NONE;
      if (primed && code != CODE_NONE && !unchanged) begin
         if (code == CODE_SUCCESS) begin
            sound = CHIME_PASS;
         end else if (code == CODE_FAILURE || code == CODE_TIMED_OUT ||
                      code == CODE_STARTUP_FAILURE) begin
            sound = CHIME_FAIL;
         end
      end
      last_code = code;
      last_run = {1'b0, run};
      primed = 1'b1;
      return sound;
   endfunction

   function automatic result_type schedule_step(input item_type s);
      result_type  r;
      logic [31:0] since_due;
      r = '0;
      if (s.target_changed) begin
         primed = 1'b0;
         last_code = CODE_NONE;
         last_run = '1;
         pending_poll = 1'b1;
      end
      if (s.request_now) begin
         pending_poll = 1'b1;
      end
      if (s.result_ready) begin
         in_flight = 1'b0;
         r.updated = 1'b1;
         if (s.result_ok) begin
            streak = '0;
            status_q = ST_OK;
            r.chime = judge_chime(s.run_id, s.conclusion_code);
         end else begin
            if (streak != FailMax) begin
               streak = streak + 1'b1;
            end
            status_q = ST_ERROR;
         end
         next_due = s.now_ms + backoff_ms();
      end
      if (!(enabled_q && s.link_up && !s.host_active && target_q)) begin
         if (owns_display) begin
            owns_display = 1'b0;
            if (!in_flight) begin
               status_q = ST_IDLE;
            end
         end
      end else begin
         if (!owns_display) begin
            owns_display = 1'b1;
            next_due = s.now_ms;
         end
         since_due = s.now_ms - next_due;
         if (in_flight) begin
            status_q = ST_POLLING;
         end else if (pending_poll || !since_due[31]) begin
            pending_poll = 1'b0;
            in_flight = 1'b1;
            status_q = ST_POLLING;
            next_due = s.now_ms + interval_s * 32'd1000;
            r.start_poll = 1'b1;
         end
      end
      r.status = status_q;
      r.driving = owns_display;
      r.failure_count = streak;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         enabled_q = 1'b1;
         interval_s = IntervalResetS;
         target_q = 1'b1;
         in_flight = 1'b0;
         owns_display = 1'b0;
         pending_poll = 1'b0;
         primed = 1'b0;
         streak = '0;
         next_due = '0;
         last_code = CODE_NONE;
         last_run = '1;
         status_q = ST_IDLE;
         step_outputs_q.delete();
         bad_outputs = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_POLL_ENABLED: begin
                  enabled_q = csr_wdata[0];
               end
               CSR_INTERVAL: begin
                  if (csr_wdata < IntervalMinS) begin
                     interval_s = IntervalMinS;
                  end else if (csr_wdata > IntervalMaxS) begin
                     interval_s = IntervalMaxS;
                  end else begin
                     interval_s = csr_wdata;
                  end
               end
               CSR_TARGET_PRESENT: begin
                  target_q = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (step_outputs_q.size() == 0) begin
               bad_outputs++;
               if (bad_outputs <= 10) begin
                  $display("%0t: status transfer with no step outstanding, tdata=%h",
                           $time, rsp_tdata);
               end
            end else begin
               want = step_outputs_q.pop_front();
               if (got.start_poll !== want.start_poll || got.status !== want.status ||
                   got.driving !== want.driving || got.updated !== want.updated ||
                   got.chime !== want.chime || got.failure_count !== want.failure_count)
               begin
                  bad_outputs++;
                  if (bad_outputs <= 10) begin
                     $display("%0t: want start=%0d status=%0d driving=%0d updated=%0d",
                              $time, want.start_poll, want.status, want.driving,
                              want.updated);
                     $display("   chime=%0d fails=%0d; got start=%0d status=%0d",
                              want.chime, want.failure_count, got.start_poll, got.status);
                     $display("   driving=%0d updated=%0d chime=%0d fails=%0d",
                              got.driving, got.updated, got.chime, got.failure_count);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_in = req_tdata[$bits(item_type)-1:0];
            step_outputs_q.push_back(schedule_step(step_in));
         end
      end
      outputs_owed = step_outputs_q.size();
   end

endmodule

[bench/backoff_poll_scheduler_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// backoff_poll_scheduler_test
// Stimulus and verdict for the backoff poll scheduler.
// ============================================================================
// A short directed sequence walks takeover, chimes, silent outcomes, failed
// results, standing down and time wrap. Random phases follow under several
// register settings (interval extremes and saturation, polling disabled, no
// target, an ignored index), one of them failure-heavy to saturate the
// failure count. Both channels idle at random; one phase holds off the
// status side for a long stretch to back the block up. Scoring is done by
// the checker instance.
// ============================================================================
module backoff_poll_scheduler_test;
   import bps_pkg::*;

   localparam logic [CsrIndexW-1:0] CsrUnused = 2'd3;
   localparam int unsigned FillW = ReqDataW - $bits(item_type);
   localparam int unsigned RspHoldCycles = 60;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RspDataW-1:0]   rsp_tdata;
   logic                  csr_we;
   logic [CsrIndexW-1:0]  csr_index;
   logic [IntervalW-1:0]  csr_wdata;

   int                    bad_outputs;
   int                    outputs_owed;

   logic                  calm = 1'b0;
   int                    rsp_holds_asked = 0;
   logic [31:0]           wall_ms;
   int unsigned           span_ms;

   backoff_poll_scheduler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   backoff_poll_scheduler_check checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .bad_outputs  (bad_outputs),
      .outputs_owed (outputs_owed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 65) begin
         return 0;
      end
      if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic item_type compose_step(input logic [31:0] now, input logic link,
                                             input logic host, input logic ask,
                                             input logic chg, input logic rdy,
                                             input logic ok, input logic [RunW-1:0] run,
                                             input logic [CodeW-1:0] code);
      item_type s;
      s.now_ms = now;
      s.link_up = link;
      s.host_active = host;
      s.request_now = ask;
      s.target_changed = chg;
      s.result_ready = rdy;
      s.result_ok = ok;
      s.run_id = run;
      s.conclusion_code = code;
      return s;
   endfunction

   function automatic item_type random_step(input int unsigned ok_pct,
                                            input int unsigned ready_pct);
      item_type    s;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         wall_ms = $urandom();
      end else if (roll < 10) begin
         wall_ms = wall_ms + $urandom_range(0, 50);
      end else begin
         wall_ms = wall_ms + $urandom_range(0, span_ms);
      end
      s.now_ms = wall_ms;
      s.link_up = ($urandom_range(0, 19) != 0);
      s.host_active = ($urandom_range(0, 11) == 0);
      s.request_now = ($urandom_range(0, 9) == 0);
      s.target_changed = ($urandom_range(0, 24) == 0);
      s.result_ready = ($urandom_range(0, 99) < ready_pct);
      s.result_ok = ($urandom_range(0, 99) < ok_pct);
      if ($urandom_range(0, 1) == 0) begin
         s.run_id = RunW'($urandom_range(0, 3));
      end else begin
         s.run_id = RunW'($urandom());
      end
      if ($urandom_range(0, 3) != 0) begin
         s.conclusion_code = CodeW'($urandom_range(0, 4));
      end else begin
         s.conclusion_code = CodeW'($urandom_range(0, 15));
      end
      return s;
   endfunction

   task automatic send_step(input item_type s);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {{FillW{1'b0}}, s};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outputs_owed != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexW-1:0] idx,
                            input logic [IntervalW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic en, input logic [IntervalW-1:0] ival,
                                input logic tgt);
      logic [IntervalW-1:0] word;
      drain_outputs();
      word = IntervalW'($urandom_range(0, 4095));
      word[0] = en;
      write_reg(CSR_POLL_ENABLED, word);
      write_reg(CSR_INTERVAL, ival);
      word = IntervalW'($urandom_range(0, 4095));
      word[0] = tgt;
      write_reg(CSR_TARGET_PRESENT, word);
      write_reg(CsrUnused, IntervalW'($urandom_range(0, 4095)));
      csr_we <= 1'b0;
   endtask

   task automatic run_steps(input int count, input int unsigned ok_pct,
                            input int unsigned ready_pct);
      repeat (count) send_step(random_step(ok_pct, ready_pct));
   endtask

   // status side: random readiness, plus a long hold-off on request
   initial begin
      int unsigned stall;
      int          holds_done;
      holds_done = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_holds_asked != holds_done) begin
            holds_done = rsp_holds_asked;
            rsp_tready <= 1'b0;
            repeat (RspHoldCycles) @(negedge clock);
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 6)) @(negedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      wall_ms = '0;
      span_ms = 20000;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: takeover, chimes, silent codes, failures, stand down, wrap
      send_step(compose_step(32'd0,     1, 0, 0, 0, 0, 0, 0, CODE_NONE));
      send_step(compose_step(32'd1000,  1, 0, 0, 0, 1, 1, 5, CODE_SUCCESS));
      send_step(compose_step(32'd2000,  1, 0, 0, 0, 1, 1, 5, CODE_SUCCESS));
      send_step(compose_step(32'd3000,  1, 0, 0, 0, 1, 1, 6, CODE_FAILURE));
      send_step(compose_step(32'd4000,  1, 0, 0, 0, 1, 1, 6, CODE_SUCCESS));
      send_step(compose_step(32'd5000,  1, 0, 0, 0, 1, 1, 7, CODE_TIMED_OUT));
      send_step(compose_step(32'd6000,  1, 0, 0, 0, 1, 1, 8, CODE_STARTUP_FAILURE));
      send_step(compose_step(32'd7000,  1, 0, 0, 0, 1, 1, 9, CODE_NONE));
      send_step(compose_step(32'd8000,  1, 0, 0, 0, 1, 1, 10, 4'd15));
      send_step(compose_step(32'd9000,  1, 0, 0, 0, 1, 1, 11, 4'd5));
      send_step(compose_step(32'd10000, 1, 0, 0, 0, 1, 0, '1, 4'd15));
      send_step(compose_step(32'd11000, 1, 0, 0, 0, 1, 0, 0, CODE_NONE));
      send_step(compose_step(32'd12000, 1, 1, 1, 0, 0, 0, 0, CODE_NONE));
      send_step(compose_step(32'd13000, 0, 0, 1, 0, 0, 0, 0, CODE_NONE));
      send_step(compose_step(32'd14000, 1, 0, 0, 0, 0, 0, 0, CODE_NONE));
      send_step(compose_step(32'd15000, 1, 0, 0, 1, 1, 1, '1, CODE_SUCCESS));
      send_step(compose_step(32'hFFFF_FFFF, 1, 0, 1, 0, 0, 0, 0, CODE_NONE));
      send_step(compose_step(32'd0,     1, 0, 0, 0, 1, 1, 0, CODE_SUCCESS));
      send_step(compose_step(32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0, CODE_NONE));
      send_step(compose_step(32'h8000_0000, 1, 0, 0, 0, 0, 0, 0, CODE_NONE));
      send_step(compose_step(32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1, '1, 4'd15));
      send_step(compose_step(32'd0,     0, 0, 0, 0, 0, 0, 0, CODE_NONE));

      wall_ms = $urandom();
      span_ms = 20000;
      run_steps(80, 60, 30);

      // shortest interval; long status hold-off while steps keep coming
      apply_setting(1'b1, 12'd0, 1'b1);
      span_ms = 5000;
      run_steps(30, 60, 30);
      rsp_holds_asked = rsp_holds_asked + 1;
      run_steps(40, 60, 30);

      apply_setting(1'b1, 12'd4095, 1'b1);
      span_ms = 1_000_000;
      run_steps(60, 60, 30);

      // failure-heavy run to saturate the failure count
      apply_setting(1'b1, IntervalMaxS, 1'b1);
      span_ms = 100000;
      run_steps(280, 0, 95);

      apply_setting(1'b0, 12'd14, 1'b1);
      span_ms = 10000;
      run_steps(25, 60, 30);

      apply_setting(1'b1, 12'd3601, 1'b0);
      span_ms = 500000;
      run_steps(25, 60, 30);

      apply_setting(1'b1, IntervalW'($urandom_range(0, 4095)), 1'b1);
      span_ms = 30000;
      calm = 1'b1;
      run_steps(35, 60, 30);
      calm = 1'b0;
      drain_outputs();
      run_steps(35, 60, 30);

      drain_outputs();
      repeat (10) @(negedge clock);
      if (bad_outputs == 0 && outputs_owed == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
